FILE: src/urxf_pkg.sv
`default_nettype none

package urxf_pkg;

    localparam int DEPTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL_W = 6;
    localparam int CMP_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;

    localparam logic [7:0] XOFF_CHAR = 8'h13;
    localparam logic [7:0] XON_CHAR  = 8'h11;

    localparam logic REG_XOFF_LEVEL = 1'b0;
    localparam logic REG_XON_LEVEL  = 1'b1;

    localparam logic [LVL_W-1:0] XOFF_LEVEL_RST = LVL_W'(24);
    localparam logic [LVL_W-1:0] XON_LEVEL_RST  = LVL_W'(3);

    typedef enum logic [1:0] {
        CMD_LINE = 2'd0,
        CMD_READ = 2'd1,
        CMD_XMIT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [LVL_W-1:0] xoff_level;
        logic [LVL_W-1:0] xon_level;
    } cfg_t;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             line_valid;
        logic [7:0]       line_byte;
        logic             read_valid;
        logic             accepted;
        logic [LVL_W-1:0] fill_level;
        logic             tx_paused;
        logic             xoff_sent;
    } res_t;

endpackage

`default_nettype wire

FILE: src/urxf_ram.sv
`default_nettype none

module urxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/urxf_regs.sv
`default_nettype none

module urxf_regs
    import urxf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.xoff_level <= XOFF_LEVEL_RST;
            cfg_reg.xon_level  <= XON_LEVEL_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_XOFF_LEVEL: cfg_reg.xoff_level <= pwdata[LVL_W-1:0];
                REG_XON_LEVEL:  cfg_reg.xon_level  <= pwdata[LVL_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_XOFF_LEVEL: prdata = {{(32-LVL_W){1'b0}}, cfg_reg.xoff_level};
            REG_XON_LEVEL:  prdata = {{(32-LVL_W){1'b0}}, cfg_reg.xon_level};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/urxf_ctrl.sv
`default_nettype none

module urxf_ctrl
    import urxf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] data_byte,
    input  wire cfg_t       cfg,
    output res_t            result,
    output mem_req_t        mem_req
);

    typedef struct packed {
        logic [PTR_W-1:0] wp;
        logic [PTR_W-1:0] rp;
        logic             full;
        logic             sent_xoff;
        logic             peer_paused;
    } st_t;

    st_t st_reg;
    st_t st_next;

    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             write_ok;
    logic [CMP_W-1:0] lvl_now;
    logic [CMP_W-1:0] lvl_wr;
    logic [CMP_W-1:0] lvl_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + 1'b1;
        ptr_inc = (sum == (PTR_W + 1)'(DEPTH)) ? '0 : sum[PTR_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] level(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp,
                                               input logic             full);
        logic [CMP_W:0] w;
        logic [CMP_W:0] r;
        w = (CMP_W + 1)'(wp);
        r = (CMP_W + 1)'(rp);
        if (full)
            level = CMP_W'(DEPTH);
        else if (wp >= rp)
            level = CMP_W'(w - r);
        else
            level = CMP_W'(w + (CMP_W + 1)'(DEPTH) - r);
    endfunction

    assign wp_inc   = ptr_inc(st_reg.wp);
    assign rp_inc   = ptr_inc(st_reg.rp);
    assign write_ok = !st_reg.full;
    assign lvl_now  = level(st_reg.wp, st_reg.rp, st_reg.full);
    assign lvl_wr   = write_ok ? level(wp_inc, st_reg.rp, wp_inc == st_reg.rp) : lvl_now;
    assign lvl_next = level(st_next.wp, st_next.rp, st_next.full);

    always_comb
    begin
        st_next           = st_reg;
        mem_req.we        = 1'b0;
        mem_req.waddr     = st_reg.wp;
        mem_req.wdata     = data_byte;
        mem_req.re        = 1'b0;
        mem_req.raddr     = st_reg.rp;
        result.line_valid = 1'b0;
        result.line_byte  = '0;
        result.read_valid = 1'b0;
        result.accepted   = 1'b0;
        case (cmd)
            CMD_LINE:
            begin
                if (data_byte == XOFF_CHAR)
                begin
                    st_next.peer_paused = 1'b1;
                end
                else if (data_byte == XON_CHAR)
                begin
                    st_next.peer_paused = 1'b0;
                end
                else
                begin
                    // drop the byte when full, but still check the XOFF mark
                    if (write_ok)
                    begin
                        mem_req.we = accept;
                        st_next.wp = wp_inc;
                        if (wp_inc == st_reg.rp)
                        begin
                            st_next.full = 1'b1;
                        end
                    end
                    if (!st_reg.sent_xoff && lvl_wr >= CMP_W'(cfg.xoff_level))
                    begin
                        result.line_valid = 1'b1;
                        result.line_byte  = XOFF_CHAR;
                        st_next.sent_xoff = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                if (st_reg.sent_xoff && lvl_now <= CMP_W'(cfg.xon_level))
                begin
                    result.line_valid = 1'b1;
                    result.line_byte  = XON_CHAR;
                    st_next.sent_xoff = 1'b0;
                end
                if (st_reg.wp != st_reg.rp || st_reg.full)
                begin
                    mem_req.re        = accept;
                    result.read_valid = 1'b1;
                    st_next.full      = 1'b0;
                    st_next.rp        = rp_inc;
                end
            end
            CMD_XMIT:
            begin
                if (!st_reg.peer_paused)
                begin
                    result.line_valid = 1'b1;
                    result.line_byte  = data_byte;
                    result.accepted   = 1'b1;
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
        result.fill_level = lvl_next[LVL_W-1:0];
        result.tx_paused  = st_next.peer_paused;
        result.xoff_sent  = st_next.sent_xoff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/uart_rx_fifo_xon_xoff_core.sv
`default_nettype none

// UART receive FIFO with XON/XOFF flow control. Each input transaction carries
// one command (line byte, host read, host transmit) and yields exactly one
// status transaction. One transaction is taken per clock; its result appears
// in the output register on the next cycle, set by the single result stage and
// the registered read port of the 32-entry byte store. A full output register
// that is not taken stalls the input side. The two level registers sit at
// byte addresses 0 (xoff_level) and 4 (xon_level) and must only be written
// while no transaction is in flight.

module uart_rx_fifo_xon_xoff_core
    import urxf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] cmd, [9:2] data_byte
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [18] accepted, [24:19] fill_level, [25] tx_paused, [26] xoff_sent
    output logic      [31:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t       cfg;
    res_t       res_next;
    res_t       res_reg;
    mem_req_t   mem_req;
    logic       accept;
    logic       m_tvalid_reg;
    logic [7:0] rdata;
    logic [7:0] read_byte;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    urxf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urxf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (s_tdata[1:0]),
        .data_byte (s_tdata[9:2]),
        .cfg       (cfg),
        .result    (res_next),
        .mem_req   (mem_req)
    );

    urxf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload holds while stalled; RAM read data only moves on accept too
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign read_byte = res_reg.read_valid ? rdata : 8'h00;

    assign m_tdata = {5'b0, res_reg.xoff_sent, res_reg.tx_paused, res_reg.fill_level,
                      res_reg.accepted, read_byte, res_reg.read_valid,
                      res_reg.line_byte, res_reg.line_valid};

endmodule

`default_nettype wire

FILE: src/urxf_checker.sv
`default_nettype none

module urxf_checker
    import urxf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled result must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side opens whenever the output register can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output register");

    // a taken host transmit always drives the line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18] |-> m_tdata[0] && !m_tdata[9])
        else $error("accepted transmit without line byte");

    // no pop means read byte zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'h00)
        else $error("read byte without pop");

    // no valid result ever comes with a fill level past depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 64) |-> m_tdata[24:19] <= LVL_W'(DEPTH))
        else $error("fill level beyond depth");

endmodule

bind uart_rx_fifo_xon_xoff_core urxf_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
